// ===== hdl/eegp_pkg.sv =====
// eegp_pkg: shared types and constants for the eeg headset packet parser
// no dependencies; used by the parser core and the top level
package eegp_pkg;

    // default payload store depth and the part of it that the result reads
    localparam int PAYLOAD_STORE_DEPTH_DEF = 32;
    localparam int KEPT_BYTES              = 32;

    // framing constants
    localparam logic [7:0] SYNC_BYTE = 8'hAA;
    localparam logic [7:0] LEN_LIMIT = 8'd170;

    // fixed payload offsets of the result fields
    localparam int OFS_SIGNAL     = 1;
    localparam int OFS_ATTENTION  = 29;
    localparam int OFS_MEDITATION = 31;
    localparam int OFS_BAND0      = 4;
    localparam int BAND_STRIDE    = 3;
    localparam int NUM_BANDS      = 8;

    // parser phases
    typedef enum logic [2:0] {
        PH_SYNC1    = 3'd0,
        PH_SYNC2    = 3'd1,
        PH_LENGTH   = 3'd2,
        PH_PAYLOAD  = 3'd3,
        PH_CHECKSUM = 3'd4
    } phase_t;

    // one frame result; band_power[0] is delta, band_power[7] is mid gamma
    typedef struct packed {
        logic                          frame_status;
        logic [7:0]                    signal_quality;
        logic [7:0]                    attention_level;
        logic [7:0]                    meditation_level;
        logic [NUM_BANDS-1:0][23:0]    band_power;
    } result_t;

endpackage

// ===== hdl/eegp_parser.sv =====
// eegp_parser: byte-wise framing state machine, checksum and payload store
// depends on eegp_pkg; the result is combinational on the accepted checksum beat
module eegp_parser #(
    parameter int PAYLOAD_STORE_DEPTH = eegp_pkg::PAYLOAD_STORE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_valid,
    input  logic [7:0]        byte_data,
    output logic              at_checksum,
    output logic              res_valid,
    output eegp_pkg::result_t res
);
    import eegp_pkg::*;

    // offsets at or above KEPT_BYTES are never read, so they are not kept
    localparam int         STORE_N   = (PAYLOAD_STORE_DEPTH < KEPT_BYTES) ?
                                       PAYLOAD_STORE_DEPTH : KEPT_BYTES;
    localparam int         IDX_W     = (STORE_N > 1) ? $clog2(STORE_N) : 1;
    localparam logic [8:0] DEPTH_LIM = 9'(STORE_N);

    phase_t     phase_reg, phase_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] pos_inc;
    logic       store_we;
    logic [7:0] store_reg [STORE_N];

    assign pos_inc     = pos_reg + 8'd1;
    assign at_checksum = (phase_reg == PH_CHECKSUM);

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SYNC1;
            len_reg   <= '0;
            pos_reg   <= '0;
            sum_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
        end
    end

    // payload store, cleared by reset, written one byte per payload beat while the offset is inside the store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STORE_N; i++) begin
                store_reg[i] <= '0;
            end
        end else if (store_we) begin
            store_reg[pos_reg[IDX_W-1:0]] <= byte_data;
        end
    end

    // next state and result
    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        store_we   = 1'b0;
        res_valid  = 1'b0;
        res        = '0;
        if (byte_valid) begin
            case (phase_reg)
                PH_SYNC2: begin
                    phase_next = (byte_data == SYNC_BYTE) ? PH_LENGTH : PH_SYNC1;
                end
                PH_LENGTH: begin
                    if (byte_data > LEN_LIMIT) begin
                        phase_next = PH_SYNC1;
                    end else if (byte_data < LEN_LIMIT) begin
                        len_next   = byte_data;
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    store_we = ({1'b0, pos_reg} < DEPTH_LIM);
                    sum_next = sum_reg + byte_data;
                    pos_next = pos_inc;
                    if (pos_inc >= len_reg) begin
                        phase_next = PH_CHECKSUM;
                    end
                end
                PH_CHECKSUM: begin
                    res_valid = 1'b1;
                    if (~sum_reg == byte_data) begin
                        res.signal_quality   = store_reg[OFS_SIGNAL];
                        res.attention_level  = store_reg[OFS_ATTENTION];
                        res.meditation_level = store_reg[OFS_MEDITATION];
                        for (int j = 0; j < NUM_BANDS; j++) begin
                            res.band_power[j] = {store_reg[OFS_BAND0 + BAND_STRIDE*j],
                                                 store_reg[OFS_BAND0 + BAND_STRIDE*j + 1],
                                                 store_reg[OFS_BAND0 + BAND_STRIDE*j + 2]};
                        end
                    end else begin
                        res.frame_status = 1'b1;
                    end
                    phase_next = PH_SYNC1;
                    len_next   = '0;
                    pos_next   = '0;
                    sum_next   = '0;
                end
                default: begin
                    phase_next = (byte_data == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
                end
            endcase
        end
    end

endmodule

// ===== hdl/eeg_headset_packet_parser_top.sv =====
// eeg_headset_packet_parser_top: byte stream in, one result beat per frame out
// depends on eegp_pkg and eegp_parser
// the result beat is registered and becomes valid in the cycle after the checksum byte is accepted
// throughput: one byte per cycle; s_ready drops only while a result beat waits
//   in the output register and the next byte is a checksum byte
// reset: synchronous active-low aresetn clears the parse state, the payload
//   store and the output valid; the block is ready in the cycle after reset
module eeg_headset_packet_parser_top #(
    parameter int PAYLOAD_STORE_DEPTH = eegp_pkg::PAYLOAD_STORE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_frame_status,
    output logic [7:0]  m_signal_quality,
    output logic [7:0]  m_attention_level,
    output logic [7:0]  m_meditation_level,
    output logic [23:0] m_delta_power,
    output logic [23:0] m_theta_power,
    output logic [23:0] m_low_alpha_power,
    output logic [23:0] m_high_alpha_power,
    output logic [23:0] m_low_beta_power,
    output logic [23:0] m_high_beta_power,
    output logic [23:0] m_low_gamma_power,
    output logic [23:0] m_mid_gamma_power
);
    import eegp_pkg::*;

    logic    byte_acc;
    logic    at_checksum;
    logic    res_valid;
    result_t res;
    result_t out_reg;
    logic    m_valid_reg;

    // hold off only a checksum byte while the output register is occupied
    assign s_ready  = !(m_valid_reg && !m_ready && at_checksum);
    assign byte_acc = s_valid && s_ready;

    eegp_parser #(
        .PAYLOAD_STORE_DEPTH(PAYLOAD_STORE_DEPTH)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_valid  (byte_acc),
        .byte_data   (s_rx_byte),
        .at_checksum (at_checksum),
        .res_valid   (res_valid),
        .res         (res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    // result beat ports
    assign m_valid            = m_valid_reg;
    assign m_frame_status     = out_reg.frame_status;
    assign m_signal_quality   = out_reg.signal_quality;
    assign m_attention_level  = out_reg.attention_level;
    assign m_meditation_level = out_reg.meditation_level;
    assign m_delta_power      = out_reg.band_power[0];
    assign m_theta_power      = out_reg.band_power[1];
    assign m_low_alpha_power  = out_reg.band_power[2];
    assign m_high_alpha_power = out_reg.band_power[3];
    assign m_low_beta_power   = out_reg.band_power[4];
    assign m_high_beta_power  = out_reg.band_power[5];
    assign m_low_gamma_power  = out_reg.band_power[6];
    assign m_mid_gamma_power  = out_reg.band_power[7];

endmodule

// ===== hdl/eegp_checker.sv =====
// eegp_checker: port-level assertions for the eeg headset packet parser
// no package needed; bound to eeg_headset_packet_parser_top below
module eegp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_rx_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_frame_status,
    input logic [7:0]  m_signal_quality,
    input logic [7:0]  m_attention_level,
    input logic [7:0]  m_meditation_level,
    input logic [23:0] m_delta_power,
    input logic [23:0] m_theta_power,
    input logic [23:0] m_low_alpha_power,
    input logic [23:0] m_high_alpha_power,
    input logic [23:0] m_low_beta_power,
    input logic [23:0] m_high_beta_power,
    input logic [23:0] m_low_gamma_power,
    input logic [23:0] m_mid_gamma_power
);

    // a stalled result beat stays valid
    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its status, its level fields and its delta and mid gamma powers
    a_payload_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_frame_status) && $stable(m_signal_quality)
            && $stable(m_attention_level) && $stable(m_meditation_level)
            && $stable(m_delta_power) && $stable(m_mid_gamma_power))
        else $error("result payload changed while stalled");

    // a checksum mismatch carries all-zero values
    a_bad_frame_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_status |-> m_signal_quality == 8'd0
            && m_attention_level == 8'd0 && m_meditation_level == 8'd0
            && m_delta_power == 24'd0 && m_theta_power == 24'd0
            && m_low_alpha_power == 24'd0 && m_high_alpha_power == 24'd0
            && m_low_beta_power == 24'd0 && m_high_beta_power == 24'd0
            && m_low_gamma_power == 24'd0 && m_mid_gamma_power == 24'd0)
        else $error("mismatched frame carries nonzero fields");

    // no result beat right after a reset cycle
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

endmodule

bind eeg_headset_packet_parser_top eegp_checker u_eegp_checker (.*);
